// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the grid path sum block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GMDPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gmdps assertion failed");
`define GMDPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gmdps assertion failed");
`else
`define GMDPS_ASSERT(lbl, clk, rst_n, prop)
`define GMDPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- hw/rtl/gmdps_pkg.sv -----
package gmdps_pkg;

  localparam int unsigned CELL_W    = 16;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned SUM_OUT_W = 22;
  localparam int unsigned COL_OUT_W = 7;

  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [SUM_OUT_W-1:0] sum_out_t;
  typedef logic [COL_OUT_W-1:0] col_out_t;

endpackage

// ----- hw/rtl/gmdps_if.sv -----
interface gmdps_in_if import gmdps_pkg::*; ();
  logic  valid;
  logic  ready;
  cell_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmdps_out_if import gmdps_pkg::*; ();
  logic     valid;
  logic     ready;
  sum_out_t best_sum;
  col_out_t best_column;

  modport source (output valid, output best_sum, output best_column, input ready);
  modport sink   (input valid, input best_sum, input best_column, output ready);
endinterface

// ----- hw/rtl/gmdps_row_mem.sv -----
module gmdps_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 23
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata0_r;
  logic [DW-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first forwarding on both read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
      rdata1_r <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ----- hw/rtl/grid_max_descending_path_sum.sv -----
// the result of a grid is on the output in the cycle after its last cell is taken
// throughput: one cell per cycle, set by the two-port row memory prefetch
// a waiting result holds back only the last cell of the next grid
// rst_n is synchronous: size 1, position and running best cleared
// row memory is not cleared: the top row writes every entry before use
`include "assert_macros.svh"

module grid_max_descending_path_sum import gmdps_pkg::*; #(
  parameter int unsigned MAX_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  gmdps_in_if.sink           in_ch,
  gmdps_out_if.source        out_ch,
  input  logic               cfg_we,
  input  cfg_t               cfg_data
);

  localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned CW = $clog2(MAX_SIZE + 1);
  localparam int unsigned SW = CELL_W + CW;
  localparam int unsigned EW = CW + CFG_W;

  logic [AW-1:0] nm1_r;
  logic [AW-1:0] row_r;
  logic [AW-1:0] col_r;
  logic [SW-1:0] left_r;
  logic [SW-1:0] run_best_r;
  logic [CW-1:0] run_col_r;
  logic          out_valid_r;
  sum_out_t      out_sum_r;
  col_out_t      out_col_r;

  logic [EW-1:0] cfg_ext;
  logic [EW-1:0] cfg_m1;
  logic [AW-1:0] nm1_nxt;

  logic          in_acc;
  logic          last_col;
  logic          bottom;
  logic          last_cell;
  logic [AW-1:0] next_col;
  logic [AW-1:0] next_col_p1;
  logic [SW-1:0] up_sum;
  logic [SW-1:0] right_sum;
  logic [SW-1:0] best_above;
  logic [SW-1:0] cell_sum;
  logic          take;
  logic [SW-1:0] cand_best;
  logic [CW-1:0] cand_col;
  logic [SW+SUM_OUT_W-1:0] cand_best_ext;
  logic [CW+COL_OUT_W-1:0] cand_col_ext;

  assign cfg_ext = EW'(cfg_data);
  assign cfg_m1  = cfg_ext - EW'(1);

  always_comb begin
    if (cfg_ext == '0) begin
      nm1_nxt = '0;
    end else if (cfg_ext > EW'(MAX_SIZE)) begin
      nm1_nxt = AW'(MAX_SIZE - 1);
    end else begin
      nm1_nxt = cfg_m1[AW-1:0];
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready || !last_cell;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign last_col    = (col_r == nm1_r);
  assign bottom      = (row_r == nm1_r);
  assign last_cell   = last_col && bottom;
  assign next_col    = last_col ? '0 : col_r + AW'(1);
  assign next_col_p1 = next_col + AW'(1);

  gmdps_row_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (AW),
    .DW    (SW)
  ) u_row_mem (
    .clk    (clk),
    .we     (in_acc),
    .waddr  (col_r),
    .wdata  (cell_sum),
    .re     (in_acc),
    .raddr0 (next_col),
    .raddr1 (next_col_p1),
    .rdata0 (up_sum),
    .rdata1 (right_sum)
  );

  always_comb begin
    best_above = up_sum;
    if ((col_r != '0) && (left_r > best_above)) begin
      best_above = left_r;
    end
    if (!last_col && (right_sum > best_above)) begin
      best_above = right_sum;
    end
  end

  assign cell_sum = (row_r == '0) ? SW'(in_ch.cell_value)
                                  : SW'(in_ch.cell_value) + best_above;

  assign take      = bottom && (cell_sum > run_best_r);
  assign cand_best = take ? cell_sum : run_best_r;
  assign cand_col  = take ? CW'(col_r) + CW'(1) : run_col_r;

  assign cand_best_ext = {{SUM_OUT_W{1'b0}}, cand_best};
  assign cand_col_ext  = {{COL_OUT_W{1'b0}}, cand_col};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm1_r      <= '0;
      row_r      <= '0;
      col_r      <= '0;
      left_r     <= '0;
      run_best_r <= '0;
      run_col_r  <= '0;
    end else if (cfg_we) begin
      nm1_r      <= nm1_nxt;
      row_r      <= '0;
      col_r      <= '0;
      left_r     <= '0;
      run_best_r <= '0;
      run_col_r  <= '0;
    end else if (in_acc) begin
      col_r  <= next_col;
      left_r <= last_col ? '0 : up_sum;
      if (last_cell) begin
        row_r      <= '0;
        run_best_r <= '0;
        run_col_r  <= '0;
      end else begin
        if (last_col) begin
          row_r <= row_r + AW'(1);
        end
        run_best_r <= cand_best;
        run_col_r  <= cand_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && last_cell) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_cell) begin
      out_sum_r <= cand_best_ext[SUM_OUT_W-1:0];
      out_col_r <= cand_col_ext[COL_OUT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_sum    = out_sum_r;
  assign out_ch.best_column = out_col_r;

  `GMDPS_ASSERT(a_pos_in_grid, clk, rst_n, (col_r <= nm1_r) && (row_r <= nm1_r))
  `GMDPS_ASSERT(a_best_col_pair, clk, rst_n, (run_col_r == '0) == (run_best_r == '0))
  `GMDPS_ASSERT(a_last_emits, clk, rst_n, in_acc && last_cell && !cfg_we |=> out_valid_r && (col_r == '0) && (row_r == '0))
  `GMDPS_ASSERT(a_mid_silent, clk, rst_n, in_acc && !last_cell && !out_valid_r |=> !out_valid_r)

endmodule

// ----- test/grid_max_descending_path_sum_test.sv -----
module grid_max_descending_path_sum_test;
  import gmdps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_MAX = 64;

  typedef struct packed {
    sum_out_t best_sum;
    col_out_t best_column;
  } path_result_t;

  typedef enum int unsigned {FILL_TINY, FILL_EXTREME, FILL_BYTE, FILL_FULL} fill_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_t cfg_data;

  gmdps_in_if  cells_if ();
  gmdps_out_if paths_if ();

  grid_max_descending_path_sum #(.MAX_SIZE(GRID_MAX)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cells_if),
    .out_ch   (paths_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // path sum predictor state
  logic [22:0]  prev_row [GRID_MAX];
  logic [22:0]  left_above;
  int unsigned  at_row;
  int unsigned  at_col;
  logic [22:0]  top_sum;
  logic [6:0]   top_col;
  cfg_t         size_reg;

  path_result_t expected_paths[$];
  path_result_t want_path;

  int unsigned error_count = 0;
  int unsigned cells_sent = 0;
  int unsigned results_checked = 0;
  int unsigned size_writes = 0;
  bit          idle_enabled = 1'b1;
  int unsigned hold_off_cycles = 0;
  int unsigned stall_left = 0;

  function automatic int unsigned grid_n();
    if (size_reg < 1) return 1;
    if (size_reg > GRID_MAX) return GRID_MAX;
    return size_reg;
  endfunction

  function automatic void restart_prediction();
    left_above = '0;
    at_row     = 0;
    at_col     = 0;
    top_sum    = '0;
    top_col    = '0;
  endfunction

  function automatic void predict_cell(cell_t v);
    int unsigned  n;
    int unsigned  c;
    logic [22:0]  above;
    logic [22:0]  best;
    logic [22:0]  sum;
    path_result_t r;
    n = grid_n();
    c = at_col;
    if (c >= n) c = n - 1;
    if (at_row >= n) at_row = n - 1;
    above = prev_row[c];
    if (at_row == 0) begin
      sum = 23'(v);
    end else begin
      best = above;
      if (c > 0 && left_above > best) best = left_above;
      if (c + 1 < n && prev_row[c+1] > best) best = prev_row[c+1];
      sum = 23'(v) + best;
    end
    left_above  = above;
    prev_row[c] = sum;
    if (at_row == n - 1 && sum > top_sum) begin
      top_sum = sum;
      top_col = 7'(c + 1);
    end
    if (c + 1 < n) begin
      at_col = c + 1;
      return;
    end
    at_col     = 0;
    left_above = '0;
    if (at_row + 1 < n) begin
      at_row = at_row + 1;
      return;
    end
    r.best_sum    = top_sum[SUM_OUT_W-1:0];
    r.best_column = top_col;
    expected_paths.push_back(r);
    restart_prediction();
  endfunction

  function automatic cell_t random_cell(fill_t fill);
    case (fill)
      FILL_TINY:    return cell_t'($urandom_range(0, 3));
      FILL_EXTREME: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      FILL_BYTE:    return cell_t'($urandom_range(0, 255));
      default:      return cell_t'($urandom());
    endcase
  endfunction

  task automatic send_cell(cell_t v);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      cells_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cells_if.valid      <= 1'b1;
    cells_if.cell_value <= v;
    do @(posedge clk); while (!cells_if.ready);
    predict_cell(v);
    cells_sent++;
  endtask

  task automatic settle_block();
    @(negedge clk);
    cells_if.valid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(cfg_t v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    size_reg = v;
    restart_prediction();
    size_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_grid(fill_t fill);
    int unsigned n;
    n = grid_n();
    repeat (n * n) send_cell(random_cell(fill));
  endtask

  // receiver: random stalls plus the long hold-off
  initial begin
    paths_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        paths_if.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        paths_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        paths_if.ready <= 1'b0;
      end else begin
        paths_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && paths_if.valid && paths_if.ready) begin
      if (expected_paths.size() == 0) begin
        $error("unexpected result best_sum=%0d best_column=%0d",
               paths_if.best_sum, paths_if.best_column);
        error_count++;
      end else begin
        want_path = expected_paths.pop_front();
        if (paths_if.best_sum !== want_path.best_sum) begin
          $error("best_sum expected %0d actual %0d", want_path.best_sum, paths_if.best_sum);
          error_count++;
        end
        if (paths_if.best_column !== want_path.best_column) begin
          $error("best_column expected %0d actual %0d",
                 want_path.best_column, paths_if.best_column);
          error_count++;
        end
        results_checked++;
      end
    end
  end

  task automatic test_reset_default();
    send_cell(16'h0000);
    send_cell(16'hFFFF);
    send_cell(16'h0001);
    settle_block();
  endtask

  task automatic test_size_extremes();
    write_size(cfg_t'(0));
    send_cell(16'h0007);
    send_cell(16'h0000);
    settle_block();
    write_size(cfg_t'(127));
    repeat (GRID_MAX + 3) send_cell(random_cell(FILL_EXTREME));
    settle_block();
  endtask

  task automatic test_ties_and_zero();
    write_size(cfg_t'(3));
    repeat (9) send_cell(16'h0000);
    repeat (9) send_cell(16'h0001);
    repeat (8) send_cell(16'h0000);
    send_cell(16'h0005);
    settle_block();
  endtask

  task automatic test_edge_neighbours();
    write_size(cfg_t'(2));
    send_cell(16'h0009); send_cell(16'h0000); send_cell(16'h0000); send_cell(16'h0000);
    send_cell(16'h0000); send_cell(16'h0009); send_cell(16'h0001); send_cell(16'h0000);
    settle_block();
    write_size(cfg_t'(3));
    send_cell(16'h0000); send_cell(16'h0000); send_cell(16'h0008);
    send_cell(16'h0000); send_cell(16'h0000); send_cell(16'h0000);
    send_cell(16'h0002); send_cell(16'h0000); send_cell(16'h0000);
    settle_block();
  endtask

  task automatic test_mid_grid_restart();
    write_size(cfg_t'(4));
    repeat (6) send_cell(random_cell(FILL_FULL));
    settle_block();
    write_size(cfg_t'(4));
    send_grid(FILL_FULL);
    repeat (3) send_cell(random_cell(FILL_FULL));
    settle_block();
    write_size(cfg_t'(5));
    send_grid(FILL_BYTE);
    settle_block();
  endtask

  task automatic test_output_backpressure();
    write_size(cfg_t'(1));
    @(posedge clk);
    hold_off_cycles = 40;
    repeat (30) send_cell(random_cell(FILL_FULL));
    settle_block();
  endtask

  task automatic test_random_grids(int unsigned cell_goal, int unsigned result_goal);
    int unsigned start_cells;
    int unsigned start_results;
    int unsigned r;
    int unsigned cells;
    cfg_t        size;
    fill_t       fill;
    bit          broken;
    start_cells   = cells_sent;
    start_results = results_checked;
    size = cfg_t'($urandom_range(1, 6));
    settle_block();
    write_size(size);
    while (cells_sent - start_cells < cell_goal ||
           results_checked - start_results < result_goal) begin
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 19);
        if (r == 0)      size = cfg_t'(0);
        else if (r == 1) size = cfg_t'($urandom_range(65, 127));
        else if (r < 4)  size = cfg_t'($urandom_range(7, 12));
        else             size = cfg_t'($urandom_range(1, 6));
        settle_block();
        write_size(size);
      end
      fill   = fill_t'($urandom_range(0, 3));
      cells  = grid_n() * grid_n();
      broken = 1'b0;
      if (size > GRID_MAX) begin
        cells  = $urandom_range(0, 100);
        broken = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        cells  = $urandom_range(0, cells - 1);
        broken = 1'b1;
      end
      repeat (cells) send_cell(random_cell(fill));
      if (broken) begin
        settle_block();
        write_size(size);
      end
    end
    settle_block();
  endtask

  task automatic test_large_random_grid();
    write_size(cfg_t'(12));
    send_grid(FILL_FULL);
    settle_block();
  endtask

  task automatic test_streaming_tail();
    idle_enabled = 1'b0;
    test_random_grids(80, 5);
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    cells_if.valid      = 1'b0;
    cells_if.cell_value = '0;
    for (int k = 0; k < GRID_MAX; k++) prev_row[k] = '0;
    size_reg = cfg_t'(1);
    restart_prediction();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_default();
    test_size_extremes();
    test_ties_and_zero();
    test_edge_neighbours();
    test_mid_grid_restart();
    test_output_backpressure();
    test_large_random_grid();
    test_random_grids(250, 10);
    test_streaming_tail();

    repeat (8) @(posedge clk);
    $display("sent %0d cells, checked %0d grid results over %0d size writes",
             cells_sent, results_checked, size_writes);
    $display("sizes 0 to 127 with clamping, ties, restarts mid-grid and a long output stall");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_paths.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
